### rtl/core/odq_pkg.sv
// Shared types and codes for the ordered deque with delete by value.
// Request and result payloads, command and status codes, cell control.
// No dependencies.
package odq_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_CLEAR      = 4'd4,
        CMD_DELETE     = 4'd5,
        CMD_READ_ALL   = 4'd6,
        CMD_READ_FIRST = 4'd7,
        CMD_READ_LAST  = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEL  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand;
    } t_in;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               has_value;
        logic               is_last;
        logic [1:0]         status;
        logic [5:0]         length;
    } t_out;

    typedef struct packed {
        logic               push_front;
        logic               push_back;
        logic               pop_front;
        logic               del_start;
        logic               del_shift;
        logic signed [31:0] operand;
    } t_cell_ctl;

endpackage

### rtl/core/odq_cell.sv
// One storage cell of the deque chain: holds one entry and a match flag.
// Takes values from its left or right neighbor for shifts and deletes.
// Depends on odq_pkg.
module odq_cell #(
    parameter int CAPACITY = 32,
    parameter int IDX      = 0
) (
    input  logic                          i_clk,
    input  odq_pkg::t_cell_ctl            i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  logic signed [31:0]            i_left,
    input  logic signed [31:0]            i_right,
    input  logic                          i_prefix,
    output logic signed [31:0]            o_value,
    output logic                          o_prefix
);
    import odq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_value, n_value;
    logic               r_match, n_match;
    logic               in_use;

    assign in_use   = CW'(IDX) < i_count;
    assign o_value  = r_value;
    assign o_prefix = i_prefix | r_match;

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        if (i_ctl.push_front) begin
            n_value = i_left;
        end else if (i_ctl.push_back && (CW'(IDX) == i_count)) begin
            n_value = i_ctl.operand;
        end else if (i_ctl.pop_front) begin
            n_value = i_right;
        end else if (i_ctl.del_shift && o_prefix) begin
            n_value = i_right;
        end
        if (i_ctl.del_start) begin
            n_match = in_use && (r_value == i_ctl.operand);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

endmodule

### rtl/core/ordered_deque_with_value_delete.sv
// Ordered deque of signed 32-bit values with delete by value, built as a cell chain.
// Channel   Dir  Handshake                   Payload
// request   in   i_in_valid / o_in_ready     i_in_data  (odq_pkg::t_in)
// result    out  o_out_valid / i_out_ready   o_out_data (odq_pkg::t_out)
// Push, pop, clear and unknown commands: one status result.
// Delete: match in every cell (S_IDLE), then shift from the first match (S_DEL).
// Read-out of n entries: take the request, then one result per cycle from the cell
// mux while the output is free; a read-out of nothing: one empty marker.
// Reset clears the count and control only; entry cells are not cleared.
// A stalled result holds in the output register; requests wait until it frees.
// Depends on odq_pkg and odq_cell.
module ordered_deque_with_value_delete #(
    parameter int CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  odq_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output odq_pkg::t_out   o_out_data
);
    import odq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_rd_left, n_rd_left;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    t_cell_ctl          ctl;
    logic signed [31:0] w_value  [CAPACITY];
    logic               w_prefix [CAPACITY];

    logic          out_free, accept, full, empty;
    logic [CW-1:0] k_sat, rd_n;
    logic [1:0]    stat;
    logic          stat_emit;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign full        = r_count >= CW'(CAPACITY);
    assign empty       = r_count == '0;

    always_comb begin
        if (i_in_data.operand[31]) begin
            k_sat = '0;
        end else if (i_in_data.operand > 32'sd0 + CAPACITY) begin
            k_sat = CW'(CAPACITY);
        end else begin
            k_sat = CW'(i_in_data.operand);
        end
        if (i_in_data.cmd == CMD_READ_ALL) begin
            rd_n = r_count;
        end else begin
            rd_n = (k_sat < r_count) ? k_sat : r_count;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [31:0] left_in, right_in;
            logic               prefix_in;
            if (gi == 0) begin : g_head
                assign left_in   = i_in_data.operand;
                assign prefix_in = 1'b0;
            end else begin : g_body
                assign left_in   = w_value[gi-1];
                assign prefix_in = w_prefix[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign right_in = w_value[gi];
            end else begin : g_mid
                assign right_in = w_value[gi+1];
            end
            odq_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (gi)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_count  (r_count),
                .i_left   (left_in),
                .i_right  (right_in),
                .i_prefix (prefix_in),
                .o_value  (w_value[gi]),
                .o_prefix (w_prefix[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_rd_left   = r_rd_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ctl         = '0;
        ctl.operand = i_in_data.operand;
        stat        = STAT_OK;
        stat_emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    stat_emit = 1'b1;
                    case (i_in_data.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (full) begin
                                stat = STAT_FULL;
                            end else begin
                                ctl.push_front = i_in_data.cmd == CMD_PUSH_FRONT;
                                ctl.push_back  = i_in_data.cmd == CMD_PUSH_BACK;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (empty) begin
                                stat = STAT_NONE;
                            end else begin
                                ctl.pop_front = i_in_data.cmd == CMD_POP_FRONT;
                                n_count       = r_count - 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_DELETE: begin
                            ctl.del_start = 1'b1;
                            stat_emit     = 1'b0;
                            n_state       = S_DEL;
                        end
                        CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
                            if (rd_n != '0) begin
                                stat_emit = 1'b0;
                                n_rd_left = rd_n;
                                n_state   = S_EMIT;
                                if (i_in_data.cmd == CMD_READ_LAST) begin
                                    n_rd_idx = IW'(r_count - rd_n);
                                end else begin
                                    n_rd_idx = '0;
                                end
                            end
                        end
                        default: begin
                            stat = STAT_OK;
                        end
                    endcase
                end
            end
            S_DEL: begin
                if (out_free) begin
                    stat_emit = 1'b1;
                    n_state   = S_IDLE;
                    if (w_prefix[CAPACITY-1]) begin
                        ctl.del_shift = 1'b1;
                        n_count       = r_count - 1'b1;
                    end else begin
                        stat = STAT_NONE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.item_value = w_value[r_rd_idx];
                    n_out.has_value  = 1'b1;
                    n_out.is_last    = r_rd_left == CW'(1);
                    n_out.status     = STAT_OK;
                    n_out.length     = 6'(r_count);
                    n_rd_idx         = r_rd_idx + 1'b1;
                    n_rd_left        = r_rd_left - 1'b1;
                    if (r_rd_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (stat_emit) begin
            n_out_valid      = 1'b1;
            n_out.item_value = '0;
            n_out.has_value  = 1'b0;
            n_out.is_last    = 1'b1;
            n_out.status     = stat;
            n_out.length     = 6'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_left   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_left   <= n_rd_left;
        end
        r_rd_idx <= n_rd_idx;
        r_out    <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("request taken while busy");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_rd_left != '0))
        else $error("read-out with nothing left");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (i_in_data.cmd == CMD_PUSH_FRONT ||
            i_in_data.cmd == CMD_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the list");

endmodule

### tb/tb_ordered_deque_with_value_delete.sv
// Testbench for ordered_deque_with_value_delete: directed table, fill, then random requests.
// Results are checked against a queue-based shadow deque with random stalls on both sides.
// Depends on odq_pkg and the ordered_deque_with_value_delete RTL.
`timescale 1ns / 100ps

module tb_ordered_deque_with_value_delete;
    import odq_pkg::*;

    localparam int CAPACITY = 32;
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] CMD_LAST_UNUSED = 4'd15;
    localparam int N_SCRIPT = 26;
    localparam int N_FILL = 34;
    localparam int N_RANDOM = 260;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] operand;
        bit                 fixed;
        logic [1:0]         st;
        logic [5:0]         len;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    bit row_fixed = 1'b0;
    t_out row_result = '0;

    logic signed [31:0] deque_shadow[$];
    t_out step_results[$];
    t_out pending_results[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int ready_run_left = 0;
    bit grow_bias = 1'b1;

    t_script_row script [N_SCRIPT] = '{
        '{CMD_POP_FRONT,  0,             1'b1, STAT_NONE, 6'd0},
        '{CMD_POP_BACK,   0,             1'b1, STAT_NONE, 6'd0},
        '{CMD_DELETE,     5,             1'b1, STAT_NONE, 6'd0},
        '{CMD_READ_ALL,   0,             1'b1, STAT_OK,   6'd0},
        '{CMD_READ_FIRST, 3,             1'b1, STAT_OK,   6'd0},
        '{CMD_READ_LAST,  32'h7FFF_FFFF, 1'b1, STAT_OK,   6'd0},
        '{CMD_CLEAR,      0,             1'b1, STAT_OK,   6'd0},
        '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, STAT_OK,   6'd1},
        '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, STAT_OK,   6'd2},
        '{CMD_PUSH_BACK,  -1,            1'b1, STAT_OK,   6'd3},
        '{CMD_PUSH_FRONT, 0,             1'b1, STAT_OK,   6'd4},
        '{CMD_READ_ALL,   0,             1'b0, STAT_OK,   6'd0},
        '{CMD_READ_FIRST, 32'h8000_0000, 1'b1, STAT_OK,   6'd4},
        '{CMD_READ_LAST,  -1,            1'b1, STAT_OK,   6'd4},
        '{CMD_READ_LAST,  32'h7FFF_FFFF, 1'b0, STAT_OK,   6'd0},
        '{CMD_READ_FIRST, 2,             1'b0, STAT_OK,   6'd0},
        '{CMD_READ_LAST,  1,             1'b0, STAT_OK,   6'd0},
        '{CMD_READ_FIRST, 0,             1'b1, STAT_OK,   6'd4},
        '{CMD_DELETE,     -1,            1'b1, STAT_OK,   6'd3},
        '{CMD_DELETE,     12345,         1'b1, STAT_NONE, 6'd3},
        '{CMD_LAST_UNUSED, -1,           1'b1, STAT_OK,   6'd3},
        '{CMD_POP_FRONT,  0,             1'b1, STAT_OK,   6'd2},
        '{CMD_POP_BACK,   0,             1'b1, STAT_OK,   6'd1},
        '{CMD_POP_BACK,   0,             1'b1, STAT_OK,   6'd0},
        '{CMD_PUSH_FRONT, 7,             1'b1, STAT_OK,   6'd1},
        '{CMD_POP_FRONT,  0,             1'b1, STAT_OK,   6'd0}
    };

    ordered_deque_with_value_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out make_result(logic signed [31:0] value, logic hv, logic last,
                                         t_status st);
        t_out r;
        r.item_value = value;
        r.has_value = hv;
        r.is_last = last;
        r.status = st;
        r.length = 6'(deque_shadow.size());
        return r;
    endfunction

    function automatic void run_deque_cmd(input t_in req);
        int k;
        int first;
        int n;
        bit found;
        bit is_read;
        t_status st;
        step_results.delete();
        st = STAT_OK;
        is_read = 1'b0;
        first = 0;
        n = 0;
        if (req.operand[31])
            k = 0;
        else if (req.operand > CAPACITY)
            k = CAPACITY;
        else
            k = req.operand;
        case (req.cmd)
            CMD_PUSH_FRONT: begin
                if (deque_shadow.size() >= CAPACITY) st = STAT_FULL;
                else deque_shadow.push_front(req.operand);
            end
            CMD_PUSH_BACK: begin
                if (deque_shadow.size() >= CAPACITY) st = STAT_FULL;
                else deque_shadow.push_back(req.operand);
            end
            CMD_POP_FRONT: begin
                if (deque_shadow.size() == 0) st = STAT_NONE;
                else void'(deque_shadow.pop_front());
            end
            CMD_POP_BACK: begin
                if (deque_shadow.size() == 0) st = STAT_NONE;
                else void'(deque_shadow.pop_back());
            end
            CMD_CLEAR: deque_shadow.delete();
            CMD_DELETE: begin
                found = 1'b0;
                for (int i = 0; i < deque_shadow.size() && !found; i++) begin
                    if (deque_shadow[i] == req.operand) begin
                        deque_shadow.delete(i);
                        found = 1'b1;
                    end
                end
                st = found ? STAT_OK : STAT_NONE;
            end
            CMD_READ_ALL: begin
                is_read = 1'b1;
                n = deque_shadow.size();
            end
            CMD_READ_FIRST: begin
                is_read = 1'b1;
                n = (k < deque_shadow.size()) ? k : deque_shadow.size();
            end
            CMD_READ_LAST: begin
                is_read = 1'b1;
                n = (k < deque_shadow.size()) ? k : deque_shadow.size();
                first = deque_shadow.size() - n;
            end
            default: ;
        endcase
        if (is_read && n > 0) begin
            for (int i = 0; i < n; i++)
                step_results.push_back(make_result(deque_shadow[first + i], 1'b1,
                                                   i == n - 1, STAT_OK));
        end else begin
            step_results.push_back(make_result('0, 1'b0, 1'b1, st));
        end
    endfunction

    task automatic note_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    task automatic check_result(t_out want, t_out got);
        if (got.item_value !== want.item_value)
            note_field("item_value", want.item_value, got.item_value);
        if (got.has_value !== want.has_value)
            note_field("has_value", want.has_value, got.has_value);
        if (got.is_last !== want.is_last)
            note_field("is_last", want.is_last, got.is_last);
        if (got.status !== want.status)
            note_field("status", want.status, got.status);
        if (got.length !== want.length)
            note_field("length", want.length, got.length);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got value %0d status %0d",
                             $time, o_out_data.item_value, o_out_data.status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_result(want, o_out_data);
                end
            end
            if (i_in_valid && o_in_ready) begin
                run_deque_cmd(i_in_data);
                if (row_fixed)
                    pending_results.push_back(row_result);
                else
                    foreach (step_results[i]) pending_results.push_back(step_results[i]);
            end
        end
    end

    always @(posedge i_clk) begin
        int r;
        if (ready_run_left > 0) begin
            ready_run_left <= ready_run_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_out_ready <= 1'b1;
                ready_run_left <= $urandom_range(0, 7);
            end else if (r < 70) begin
                i_out_ready <= 1'b1;
                ready_run_left <= $urandom_range(20, 60);
            end else if (r < 95) begin
                i_out_ready <= 1'b0;
                ready_run_left <= $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                ready_run_left <= $urandom_range(10, 30);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(5, 25);
        burst_left = $urandom_range(15, 30);
        return 0;
    endfunction

    function automatic logic signed [31:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return int'($urandom_range(0, 8)) - 4;
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [31:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom | 32'h8000_0000;
        if (r < 20) return $urandom_range(CAPACITY + 1, 32'h7FFF_FFFF);
        return $urandom_range(0, CAPACITY + 2);
    endfunction

    task automatic make_request(output t_in req);
        int r;
        int p_push;
        int p_pop;
        int p_del;
        p_push = grow_bias ? 55 : 22;
        p_pop = grow_bias ? 65 : 55;
        p_del = grow_bias ? 77 : 70;
        r = $urandom_range(0, 99);
        req.operand = $urandom;
        if (r < p_push) begin
            req.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            req.operand = rand_value();
        end else if (r < p_pop) begin
            req.cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end else if (r < p_del) begin
            req.cmd = CMD_DELETE;
            if (deque_shadow.size() > 0 && $urandom_range(0, 1))
                req.operand = deque_shadow[$urandom_range(0, deque_shadow.size() - 1)];
            else
                req.operand = rand_value();
        end else if (r < 95) begin
            req.cmd = 4'($urandom_range(CMD_READ_ALL, CMD_READ_LAST));
            req.operand = rand_count();
        end else if (r < 97) begin
            req.cmd = CMD_CLEAR;
        end else begin
            req.cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        end
    endtask

    task automatic send_req(input t_in req, input bit fixed, input t_out fixed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        row_fixed <= fixed;
        row_result <= fixed_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results_done(int limit);
        int waited;
        waited = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_in req;
        t_out fixed_res;
        int bias_left;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            req.cmd = script[i].cmd;
            req.operand = script[i].operand;
            fixed_res = '0;
            fixed_res.is_last = 1'b1;
            fixed_res.status = script[i].st;
            fixed_res.length = script[i].len;
            send_req(req, script[i].fixed, fixed_res);
        end

        // fill past capacity, then read the full list
        for (int i = 0; i < N_FILL; i++) begin
            if (i == N_FILL - 2) req.cmd = CMD_PUSH_FRONT;
            else if (i == N_FILL - 1) req.cmd = CMD_PUSH_BACK;
            else req.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            req.operand = rand_value();
            send_req(req, 1'b0, '0);
        end
        req = '{CMD_READ_ALL, 0};
        send_req(req, 1'b0, '0);
        req = '{CMD_READ_LAST, CAPACITY + 8};
        send_req(req, 1'b0, '0);
        req = '{CMD_READ_FIRST, CAPACITY};
        send_req(req, 1'b0, '0);
        req = '{CMD_CLEAR, 0};
        send_req(req, 1'b0, '0);

        bias_left = $urandom_range(30, 60);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                wait_results_done(100_000);
            end
            if (bias_left == 0) begin
                grow_bias = ~grow_bias;
                bias_left = $urandom_range(30, 60);
            end
            bias_left--;
            make_request(req);
            send_req(req, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        wait_results_done(100_000);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results expected but never seen", $time,
                     pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/odq_pkg.sv
rtl/core/odq_cell.sv
rtl/core/ordered_deque_with_value_delete.sv
tb/tb_ordered_deque_with_value_delete.sv
